// ----- rtl/core/chip8_instruction_core_defines.svh -----
// Assertion macros for the CHIP-8 instruction core.
// Used only from the top level; expects clk_i and rst_ni in scope.
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define CHIP8IC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define CHIP8IC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHIP8IC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/chip8ic_pkg.sv -----
// Shared types, constants and helper functions for the CHIP-8 instruction core.
// No dependencies; compiled first.
package chip8ic_pkg;

  localparam int unsigned AddrW      = 12;
  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned RowW       = $clog2(ScreenH);
  localparam int unsigned RegCount   = 16;
  localparam int unsigned RegW       = $clog2(RegCount);
  localparam int unsigned KeyTotal   = 16;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned StackAw    = $clog2(StackDepth);
  localparam int unsigned LvlW       = $clog2(StackDepth + 1);
  localparam int unsigned IdxW       = 16;

  localparam logic [AddrW-1:0] PcReset = AddrW'(512);

  typedef enum logic [1:0] {
    FN_STEP = 2'd0,
    FN_TICK = 2'd1,
    FN_LOAD = 2'd2,
    FN_READ = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_WAITKEY   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_LOAD, S_RDROW, S_RDROW_CAP,
    S_FETCH_HI, S_FETCH_LO, S_FETCH_CAP,
    S_RD_X, S_RD_Y, S_RD_CAP, S_EXEC, S_WB_X, S_RET,
    S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
    S_DR_MEM, S_DR_ROW, S_DR_XOR, S_DR_FLAG, S_DONE
  } state_e;

  // top nibble of the opcode
  localparam logic [3:0] OpSys  = 4'h0;
  localparam logic [3:0] OpJp   = 4'h1;
  localparam logic [3:0] OpCall = 4'h2;
  localparam logic [3:0] OpSeq  = 4'h3;
  localparam logic [3:0] OpSne  = 4'h4;
  localparam logic [3:0] OpSeqV = 4'h5;
  localparam logic [3:0] OpLd   = 4'h6;
  localparam logic [3:0] OpAdd  = 4'h7;
  localparam logic [3:0] OpAlu  = 4'h8;
  localparam logic [3:0] OpSneV = 4'h9;
  localparam logic [3:0] OpLdI  = 4'hA;
  localparam logic [3:0] OpJpV0 = 4'hB;
  localparam logic [3:0] OpRnd  = 4'hC;
  localparam logic [3:0] OpDraw = 4'hD;
  localparam logic [3:0] OpKey  = 4'hE;
  localparam logic [3:0] OpMisc = 4'hF;

  // 8XYn sub-operations
  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // low-byte codes
  localparam logic [7:0] NnCls     = 8'hE0;
  localparam logic [7:0] NnRet     = 8'hEE;
  localparam logic [7:0] NnSkp     = 8'h9E;
  localparam logic [7:0] NnSknp    = 8'hA1;
  localparam logic [7:0] NnGetDt   = 8'h07;
  localparam logic [7:0] NnWaitKey = 8'h0A;
  localparam logic [7:0] NnSetDt   = 8'h15;
  localparam logic [7:0] NnSetSt   = 8'h18;
  localparam logic [7:0] NnAddI    = 8'h1E;
  localparam logic [7:0] NnFont    = 8'h29;
  localparam logic [7:0] NnBcd     = 8'h33;
  localparam logic [7:0] NnStore   = 8'h55;
  localparam logic [7:0] NnLoad    = 8'h65;

  localparam logic [3:0] FlagReg = 4'hF;

  // {hundreds, tens, ones} of an 8-bit value
  function automatic logic [11:0] bcd_digits(logic [7:0] v);
    logic [7:0] r;
    logic [3:0] h;
    logic [3:0] t;
    logic [7:0] o;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = v - 8'd100;
    end else begin
      h = 4'd0;
      r = v;
    end
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= 8'(10 * k)) t = 4'(k);
    end
    o = r - ({4'd0, t} << 3) - ({4'd0, t} << 1);
    return {h, t, o[3:0]};
  endfunction

  // sprite byte placed at column ox, wrapping around the row
  function automatic logic [ScreenW-1:0] sprite_mask(logic [7:0] spr,
                                                     logic [RowW:0] ox);
    logic [ScreenW-1:0]   s;
    logic [2*ScreenW-1:0] w;
    s = {spr, (ScreenW - 8)'(0)};
    w = {s, s} >> ox;
    return w[ScreenW-1:0];
  endfunction

endpackage

// ----- rtl/core/chip8ic_if.sv -----
// Request and response channel interfaces of the CHIP-8 instruction core.
// Depends on chip8ic_pkg for widths.
interface chip8ic_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [chip8ic_pkg::AddrW-1:0]  address;
  logic [7:0]                     data;
  logic [chip8ic_pkg::RowW-1:0]   row_select;
  logic [7:0]                     random_byte;
  logic [chip8ic_pkg::KeyTotal-1:0] key_mask;

  modport source (output valid, func, address, data, row_select, random_byte, key_mask,
                  input ready);
  modport sink (input valid, func, address, data, row_select, random_byte, key_mask,
                output ready);
endinterface

interface chip8ic_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic [15:0]                     opcode_seen;
  logic [chip8ic_pkg::AddrW-1:0]   pc_now;
  logic                            beep;
  logic [chip8ic_pkg::ScreenW-1:0] fb_row;

  modport source (output valid, status, opcode_seen, pc_now, beep, fb_row, input ready);
  modport sink (input valid, status, opcode_seen, pc_now, beep, fb_row, output ready);
endinterface

// ----- rtl/core/chip8_instruction_core.sv -----
// CHIP-8 instruction core: sequencer, register file, memories and output register.
// Depends on chip8ic_pkg, chip8ic_if and chip8_instruction_core_defines.svh.
//
//  channel | dir | handshake    | carries
//  --------+-----+--------------+----------------------------------------------
//  req_i   | in  | valid/ready  | func, address, data, row_select, rnd, keys
//  rsp_o   | out | valid/ready  | status, opcode_seen, pc_now, beep, fb_row
//  cfg     | in  | cfg_we_i     | pc_start (12 bits), no read-back
//
// One request at a time; ready is high only while the sequencer is idle.
// Load and tick use their own state, read a row read and capture; a step fetches,
// reads operands, executes and outputs; ALU flag ops and return add a write-back or
// return state, BCD a state per digit, FX55/FX65 a read and a write state per byte,
// DXYN a memory, row and XOR state per sprite row plus a flag write. Memory, register
// file, stack and frame rows have one write and one read port and registered reads.
// Reset clears control state and the register file / frame valid bits at once; no clearing pass.
// A finished response waits in the output register; the next request is taken
// meanwhile and only its own completion waits for rsp_o.ready.
`include "chip8_instruction_core_defines.svh"

module chip8_instruction_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [chip8ic_pkg::AddrW-1:0] cfg_data_i,
  chip8ic_req_if.sink                   req_i,
  chip8ic_rsp_if.source                 rsp_o
);
  import chip8ic_pkg::*;

  state_e state_q, state_d;

  logic [AddrW-1:0] pc_start_q, pc_q, pc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [7:0]       dt_q, dt_d, st_q, st_d;

  // latched request
  func_e                func_q;
  logic [AddrW-1:0]     addr_q;
  logic [7:0]           data_q;
  logic [RowW-1:0]      rowsel_q;
  logic [7:0]           rnd_q;
  logic [KeyTotal-1:0]  keys_q;
  logic                 req_fire;

  // working registers
  logic [15:0]        op_q, op_d;
  logic [7:0]         hi_q, hi_d, a_q, a_d, b_q, b_d, res_q, res_d, spr_q, spr_d;
  logic [RegW-1:0]    cnt_q, cnt_d;
  logic               col_q, col_d;
  status_e            status_q, status_d;
  logic               beep_q, beep_d;
  logic [ScreenW-1:0] row_q, row_d;

  // output register
  logic               ov_q;
  logic               out_load;
  status_e            o_status_q;
  logic [15:0]        o_op_q;
  logic [AddrW-1:0]   o_pc_q;
  logic               o_beep_q;
  logic [ScreenW-1:0] o_row_q;

  // main memory
  logic [7:0]       mem [MemBytes];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rd_q;

  // register file
  logic [7:0]          vr_mem [RegCount];
  logic [RegCount-1:0] vr_vld_q;
  logic                vr_we;
  logic [RegW-1:0]     vr_waddr, vr_raddr;
  logic [7:0]          vr_wdata, vr_rdat_q, vreg_rd;
  logic                vr_rvld_q;

  // return stack
  logic [AddrW-1:0]   stk_mem [StackDepth];
  logic               stk_we;
  logic [StackAw-1:0] stk_waddr, stk_raddr;
  logic [AddrW-1:0]   stk_wdata, stk_rd_q;

  // frame rows
  logic [ScreenW-1:0] fb_mem [ScreenH];
  logic [ScreenH-1:0] fb_vld_q;
  logic               fb_we, fb_clr;
  logic [RowW-1:0]    fb_waddr, fb_raddr;
  logic [ScreenW-1:0] fb_wdata, fb_rdat_q, fb_rd;
  logic               fb_rvld_q;

  // decode helpers
  logic [3:0]       opc, opx, opy, opn;
  logic [7:0]       nn;
  logic [AddrW-1:0] nnn, pc2, pc4;
  logic [AddrW-1:0] idx_addr;
  logic [RowW-1:0]  py;
  logic [11:0]      digits;
  logic [ScreenW-1:0] mask;
  logic [8:0]       sum;
  logic [7:0]       alu_a, alu_b;
  logic             alu_cin;
  logic             alu_flag;
  logic [7:0]       alu_ea, alu_eb;

  assign opc = op_q[15:12];
  assign opx = op_q[11:8];
  assign opy = op_q[7:4];
  assign opn = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc2 = pc_q + AddrW'(2);
  assign pc4 = pc_q + AddrW'(4);
  assign idx_addr = idx_q[AddrW-1:0] + AddrW'(cnt_q);
  assign py = b_q[RowW-1:0] + RowW'(cnt_q);
  assign digits = bcd_digits(a_q);
  assign mask = sprite_mask(spr_q, a_q[RowW:0]);
  assign vreg_rd = vr_rvld_q ? vr_rdat_q : 8'd0;
  assign fb_rd = fb_rvld_q ? fb_rdat_q : '0;

  // shared 8-bit adder: add, subtract and reverse subtract
  assign sum = {1'b0, alu_a} + {1'b0, alu_b} + {8'd0, alu_cin};

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire = req_i.valid && req_i.ready;
  assign out_load = (state_q == S_DONE) && (!ov_q || rsp_o.ready);

  // VF is written before Vx, so for subtract and shift an operand that is VF sees the new flag
  always_comb begin
    case (opn)
      AluSub:  alu_flag = (a_q > b_q);
      AluSubn: alu_flag = (b_q > a_q);
      AluShr:  alu_flag = a_q[0];
      default: alu_flag = a_q[7];
    endcase
  end

  assign alu_ea = (opx == FlagReg) ? {7'd0, alu_flag} : a_q;
  assign alu_eb = (opy == FlagReg) ? {7'd0, alu_flag} : b_q;

  always_comb begin
    alu_a   = a_q;
    alu_b   = nn;
    alu_cin = 1'b0;
    if (opc == OpAlu) begin
      case (opn)
        AluSub: begin
          alu_a   = alu_ea;
          alu_b   = ~alu_eb;
          alu_cin = 1'b1;
        end
        AluSubn: begin
          alu_a   = alu_eb;
          alu_b   = ~alu_ea;
          alu_cin = 1'b1;
        end
        default: alu_b = b_q;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    idx_d     = idx_q;
    lvl_d     = lvl_q;
    dt_d      = dt_q;
    st_d      = st_q;
    op_d      = op_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    spr_d     = spr_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    status_d  = status_q;
    beep_d    = beep_q;
    row_d     = row_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = data_q;
    mem_raddr = pc_q;
    vr_we     = 1'b0;
    vr_waddr  = opx;
    vr_wdata  = res_q;
    vr_raddr  = opx;
    stk_we    = 1'b0;
    stk_waddr = lvl_q[StackAw-1:0];
    stk_wdata = pc_q;
    stk_raddr = StackAw'(lvl_q - LvlW'(1));
    fb_we     = 1'b0;
    fb_clr    = 1'b0;
    fb_waddr  = py;
    fb_wdata  = fb_rd ^ mask;
    fb_raddr  = py;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          status_d = ST_OK;
          beep_d   = 1'b0;
          row_d    = '0;
          op_d     = '0;
          case (func_e'(req_i.func))
            FN_STEP: state_d = S_FETCH_HI;
            FN_TICK: state_d = S_TICK;
            FN_LOAD: state_d = S_LOAD;
            default: state_d = S_RDROW;
          endcase
        end
      end
      S_TICK: begin
        if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
        if (st_q != 8'd0) begin
          st_d   = st_q - 8'd1;
          beep_d = (st_q == 8'd2);
        end
        state_d = S_DONE;
      end
      S_LOAD: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_RDROW: begin
        fb_raddr = rowsel_q;
        state_d  = S_RDROW_CAP;
      end
      S_RDROW_CAP: begin
        row_d   = fb_rd;
        state_d = S_DONE;
      end
      S_FETCH_HI: begin
        mem_raddr = pc_q;
        state_d   = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        mem_raddr = pc_q + AddrW'(1);
        hi_d      = mem_rd_q;
        state_d   = S_FETCH_CAP;
      end
      S_FETCH_CAP: begin
        op_d    = {hi_q, mem_rd_q};
        state_d = S_RD_X;
      end
      S_RD_X: begin
        vr_raddr = opx;
        state_d  = S_RD_Y;
      end
      S_RD_Y: begin
        a_d      = vreg_rd;
        // BNNN needs V0 in the second operand
        vr_raddr = (opc == OpJpV0) ? '0 : opy;
        state_d  = S_RD_CAP;
      end
      S_RD_CAP: begin
        b_d     = vreg_rd;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (opc)
          OpSys: begin
            if (nn == NnCls) begin
              fb_clr = 1'b1;
              pc_d   = pc2;
            end else if (nn == NnRet) begin
              if (lvl_q == '0) status_d = ST_UNDERFLOW;
              else state_d = S_RET;
            end else begin
              status_d = ST_UNKNOWN;
            end
          end
          OpJp: pc_d = nnn;
          OpCall: begin
            if (lvl_q >= LvlW'(StackDepth)) begin
              status_d = ST_OVERFLOW;
            end else begin
              stk_we = 1'b1;
              lvl_d  = lvl_q + LvlW'(1);
              pc_d   = nnn;
            end
          end
          OpSeq:  pc_d = (a_q == nn) ? pc4 : pc2;
          OpSne:  pc_d = (a_q != nn) ? pc4 : pc2;
          OpSeqV: pc_d = (a_q == b_q) ? pc4 : pc2;
          OpSneV: pc_d = (a_q != b_q) ? pc4 : pc2;
          OpLd: begin
            vr_we    = 1'b1;
            vr_wdata = nn;
            pc_d     = pc2;
          end
          OpAdd: begin
            vr_we    = 1'b1;
            vr_wdata = sum[7:0];
            pc_d     = pc2;
          end
          OpAlu: begin
            // flag goes first, Vx follows in S_WB_X so VX=F wins
            vr_waddr = FlagReg;
            pc_d     = pc2;
            state_d  = S_WB_X;
            case (opn)
              AluMov: begin
                vr_we = 1'b1; vr_waddr = opx; vr_wdata = b_q; state_d = S_DONE;
              end
              AluOr: begin
                vr_we = 1'b1; vr_waddr = opx; vr_wdata = a_q | b_q; state_d = S_DONE;
              end
              AluAnd: begin
                vr_we = 1'b1; vr_waddr = opx; vr_wdata = a_q & b_q; state_d = S_DONE;
              end
              AluXor: begin
                vr_we = 1'b1; vr_waddr = opx; vr_wdata = a_q ^ b_q; state_d = S_DONE;
              end
              AluAdd: begin
                vr_we = 1'b1; vr_wdata = {7'd0, sum[8]}; res_d = sum[7:0];
              end
              AluSub: begin
                vr_we = 1'b1; vr_wdata = {7'd0, alu_flag}; res_d = sum[7:0];
              end
              AluSubn: begin
                vr_we = 1'b1; vr_wdata = {7'd0, alu_flag}; res_d = sum[7:0];
              end
              AluShr: begin
                vr_we = 1'b1; vr_wdata = {7'd0, alu_flag}; res_d = {1'b0, alu_ea[7:1]};
              end
              AluShl: begin
                vr_we = 1'b1; vr_wdata = {7'd0, alu_flag}; res_d = {alu_ea[6:0], 1'b0};
              end
              default: begin
                status_d = ST_UNKNOWN;
                pc_d     = pc_q;
                state_d  = S_DONE;
              end
            endcase
          end
          OpLdI:  begin
            idx_d = IdxW'(nnn);
            pc_d  = pc2;
          end
          OpJpV0: pc_d = nnn + AddrW'(b_q);
          OpRnd: begin
            vr_we    = 1'b1;
            vr_wdata = rnd_q & nn;
            pc_d     = pc2;
          end
          OpDraw: begin
            col_d   = 1'b0;
            cnt_d   = '0;
            pc_d    = pc2;
            state_d = (opn == 4'd0) ? S_DR_FLAG : S_DR_MEM;
          end
          OpKey: begin
            if (nn == NnSkp) pc_d = keys_q[a_q[RegW-1:0]] ? pc4 : pc2;
            else if (nn == NnSknp) pc_d = keys_q[a_q[RegW-1:0]] ? pc2 : pc4;
            else status_d = ST_UNKNOWN;
          end
          default: begin
            pc_d  = pc2;
            cnt_d = '0;
            case (nn)
              NnGetDt: begin
                vr_we    = 1'b1;
                vr_wdata = dt_q;
              end
              NnWaitKey: begin
                status_d = ST_WAITKEY;
                pc_d     = pc_q;
              end
              NnSetDt: dt_d = a_q;
              NnSetSt: st_d = a_q;
              NnAddI:  idx_d = idx_q + IdxW'(a_q);
              NnFont:  idx_d = (IdxW'(a_q) << 2) + IdxW'(a_q);
              NnBcd:   state_d = S_BCD;
              NnStore: state_d = S_ST_RD;
              NnLoad:  state_d = S_LD_RD;
              default: begin
                status_d = ST_UNKNOWN;
                pc_d     = pc_q;
              end
            endcase
          end
        endcase
      end
      S_WB_X: begin
        vr_we    = 1'b1;
        vr_waddr = opx;
        vr_wdata = res_q;
        state_d  = S_DONE;
      end
      S_RET: begin
        pc_d    = stk_rd_q + AddrW'(2);
        lvl_d   = lvl_q - LvlW'(1);
        state_d = S_DONE;
      end
      S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = idx_addr;
        case (cnt_q)
          4'd0:    mem_wdata = {4'd0, digits[11:8]};
          4'd1:    mem_wdata = {4'd0, digits[7:4]};
          default: mem_wdata = {4'd0, digits[3:0]};
        endcase
        if (cnt_q == 4'd2) state_d = S_DONE;
        else cnt_d = cnt_q + 4'd1;
      end
      S_ST_RD: begin
        vr_raddr = cnt_q;
        state_d  = S_ST_WR;
      end
      S_ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_addr;
        mem_wdata = vreg_rd;
        if (cnt_q == opx) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_ST_RD;
        end
      end
      S_LD_RD: begin
        mem_raddr = idx_addr;
        state_d   = S_LD_WR;
      end
      S_LD_WR: begin
        vr_we    = 1'b1;
        vr_waddr = cnt_q;
        vr_wdata = mem_rd_q;
        if (cnt_q == opx) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_LD_RD;
        end
      end
      S_DR_MEM: begin
        mem_raddr = idx_addr;
        state_d   = S_DR_ROW;
      end
      S_DR_ROW: begin
        spr_d    = mem_rd_q;
        fb_raddr = py;
        state_d  = S_DR_XOR;
      end
      S_DR_XOR: begin
        fb_we = 1'b1;
        if ((fb_rd & mask) != '0) col_d = 1'b1;
        if (cnt_q == opn - 4'd1) begin
          state_d = S_DR_FLAG;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = S_DR_MEM;
        end
      end
      S_DR_FLAG: begin
        vr_we    = 1'b1;
        vr_waddr = FlagReg;
        vr_wdata = {7'd0, col_q};
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_start_q <= PcReset;
      pc_q       <= PcReset;
      idx_q      <= '0;
      lvl_q      <= '0;
      dt_q       <= '0;
      st_q       <= '0;
      ov_q       <= 1'b0;
      vr_vld_q   <= '0;
      fb_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pc_start_q <= cfg_data_i;
      pc_q  <= pc_d;
      idx_q <= idx_d;
      lvl_q <= lvl_d;
      dt_q  <= dt_d;
      st_q  <= st_d;
      if (out_load) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
      if (vr_we) vr_vld_q[vr_waddr] <= 1'b1;
      if (fb_clr) fb_vld_q <= '0;
      else if (fb_we) fb_vld_q[fb_waddr] <= 1'b1;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      func_q   <= func_e'(req_i.func);
      addr_q   <= req_i.address;
      data_q   <= req_i.data;
      rowsel_q <= req_i.row_select;
      rnd_q    <= req_i.random_byte;
      keys_q   <= req_i.key_mask;
    end
    op_q     <= op_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    spr_q    <= spr_d;
    cnt_q    <= cnt_d;
    col_q    <= col_d;
    status_q <= status_d;
    beep_q   <= beep_d;
    row_q    <= row_d;
    if (out_load) begin
      o_status_q <= status_q;
      o_op_q     <= (func_q == FN_STEP) ? op_q : 16'd0;
      o_pc_q     <= pc_q;
      o_beep_q   <= beep_q;
      o_row_q    <= row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vr_we) vr_mem[vr_waddr] <= vr_wdata;
    vr_rdat_q <= vr_mem[vr_raddr];
    vr_rvld_q <= vr_vld_q[vr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[fb_waddr] <= fb_wdata;
    fb_rdat_q <= fb_mem[fb_raddr];
    fb_rvld_q <= fb_vld_q[fb_raddr];
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = o_status_q;
  assign rsp_o.opcode_seen = o_op_q;
  assign rsp_o.pc_now      = o_pc_q;
  assign rsp_o.beep        = o_beep_q;
  assign rsp_o.fb_row      = o_row_q;

  `CHIP8IC_ASSERT(a_lvl_bound, lvl_q <= LvlW'(StackDepth), "stack level past depth")
  `CHIP8IC_ASSERT_NEXT(a_busy_after_req, req_fire, state_q != S_IDLE, "request not started")
  `CHIP8IC_ASSERT_IMPL(a_done_waits, (state_q == S_DONE) && ov_q && !rsp_o.ready,
    state_d == S_DONE, "response overwrote pending one")
  `CHIP8IC_ASSERT_IMPL(a_beep_ok, rsp_o.valid && rsp_o.beep,
    rsp_o.status == ST_OK && rsp_o.opcode_seen == 16'd0, "beep on non-tick response")

endmodule

// ----- sim/chip8_instruction_core_tb.sv -----
// Testbench for chip8_instruction_core: random and directed requests checked against
// an in-bench interpreter model. Needs chip8ic_pkg, chip8ic_if and the core RTL.
`timescale 1ns / 100ps

module chip8_instruction_core_tb;
  import chip8ic_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseItems = 255;

  typedef struct {
    logic [1:0]  func;
    logic [11:0] address;
    logic [7:0]  data;
    logic [4:0]  row_select;
    logic [7:0]  random_byte;
    logic [15:0] key_mask;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] opcode_seen;
    logic [11:0] pc_now;
    logic        beep;
    logic [63:0] fb_row;
  } response_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [11:0] cfg_data;

  chip8ic_req_if rq ();
  chip8ic_rsp_if rs ();

  chip8_instruction_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .req_i     (rq),
    .rsp_o     (rs)
  );

  // interpreter shadow state
  logic [11:0] boot_pc;
  logic [7:0]  vr [16];
  logic [15:0] ir;
  logic [11:0] pc;
  logic [11:0] ret_stack [16];
  int          depth;
  logic [7:0]  delay_t;
  logic [7:0]  sound_t;
  logic [7:0]  mem [4096];
  bit          written [4096];
  logic [63:0] screen [32];

  request_t  pending_reqs [$];
  response_t expected_rsps [$];

  int  errors;
  int  phase_items;
  int  cycle_count;
  int  idle_pct;
  int  stall_pct;
  bit  req_fired;
  bit  req_busy;

  always #2 clk_i = ~clk_i;

  function automatic void mem_wr(logic [11:0] a, logic [7:0] v);
    mem[a]     = v;
    written[a] = 1'b1;
  endfunction

  function automatic void advance(logic [11:0] by);
    pc = pc + by;
  endfunction

  function automatic status_e run_opcode(logic [15:0] op, logic [7:0] rnd, logic [15:0] keys);
    logic [11:0] nnn;
    logic [7:0]  nn;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  bits;
    logic [3:0]  n;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [8:0]  s;
    logic [63:0] m;
    int          ox;
    int          oy;
    int          py;
    int          px;
    nnn = op[11:0];
    nn  = op[7:0];
    n   = op[3:0];
    x   = op[11:8];
    y   = op[7:4];
    case (op[15:12])
      OpSys: begin
        if (nn == NnCls) begin
          for (int k = 0; k < 32; k++) screen[k] = '0;
          advance(2);
        end else if (nn == NnRet) begin
          if (depth == 0) return ST_UNDERFLOW;
          depth--;
          pc = ret_stack[depth];
          advance(2);
        end else return ST_UNKNOWN;
      end
      OpJp: pc = nnn;
      OpCall: begin
        if (depth >= 16) return ST_OVERFLOW;
        ret_stack[depth] = pc;
        depth++;
        pc = nnn;
      end
      OpSeq:  advance(vr[x] == nn ? 4 : 2);
      OpSne:  advance(vr[x] != nn ? 4 : 2);
      OpSeqV: advance(vr[x] == vr[y] ? 4 : 2);
      OpLd: begin
        vr[x] = nn;
        advance(2);
      end
      OpAdd: begin
        vr[x] = vr[x] + nn;
        advance(2);
      end
      OpAlu: begin
        a = vr[x];
        b = vr[y];
        case (n)
          AluMov: vr[x] = b;
          AluOr:  vr[x] = a | b;
          AluAnd: vr[x] = a & b;
          AluXor: vr[x] = a ^ b;
          AluAdd: begin
            s = {1'b0, a} + {1'b0, b};
            vr[FlagReg] = {7'd0, s[8]};
            vr[x] = s[7:0];
          end
          // flag first, then the operation on the updated file
          AluSub: begin
            vr[FlagReg] = (a > b) ? 8'd1 : 8'd0;
            vr[x] = vr[x] - vr[y];
          end
          AluShr: begin
            vr[FlagReg] = {7'd0, a[0]};
            vr[x] = vr[x] >> 1;
          end
          AluSubn: begin
            vr[FlagReg] = (b > a) ? 8'd1 : 8'd0;
            vr[x] = vr[y] - vr[x];
          end
          AluShl: begin
            vr[FlagReg] = {7'd0, a[7]};
            vr[x] = vr[x] << 1;
          end
          default: return ST_UNKNOWN;
        endcase
        advance(2);
      end
      OpSneV: advance(vr[x] != vr[y] ? 4 : 2);
      OpLdI: begin
        ir = {4'd0, nnn};
        advance(2);
      end
      OpJpV0: pc = nnn + {4'd0, vr[0]};
      OpRnd: begin
        vr[x] = rnd & nn;
        advance(2);
      end
      OpDraw: begin
        ox = vr[x];
        oy = vr[y];
        vr[FlagReg] = 8'd0;
        for (int r = 0; r < n; r++) begin
          bits = mem[12'(ir + r)];
          py = (oy + r) % 32;
          for (int c = 0; c < 8; c++) begin
            if (bits[7-c]) begin
              px = (ox + c) % 64;
              m = 64'd1 << (63 - px);
              if ((screen[py] & m) != 0) vr[FlagReg] = 8'd1;
              screen[py] = screen[py] ^ m;
            end
          end
        end
        advance(2);
      end
      OpKey: begin
        if (nn == NnSkp) advance(keys[vr[x][3:0]] ? 4 : 2);
        else if (nn == NnSknp) advance(!keys[vr[x][3:0]] ? 4 : 2);
        else return ST_UNKNOWN;
      end
      default: begin
        case (nn)
          NnGetDt:   vr[x] = delay_t;
          NnWaitKey: return ST_WAITKEY;
          NnSetDt:   delay_t = vr[x];
          NnSetSt:   sound_t = vr[x];
          NnAddI:    ir = ir + {8'd0, vr[x]};
          NnFont:    ir = 16'd5 * {8'd0, vr[x]};
          NnBcd: begin
            mem_wr(12'(ir), 8'(vr[x] / 100));
            mem_wr(12'(ir + 1), 8'((vr[x] % 100) / 10));
            mem_wr(12'(ir + 2), 8'(vr[x] % 10));
          end
          NnStore: for (int k = 0; k <= x; k++) mem_wr(12'(ir + k), vr[k]);
          NnLoad:  for (int k = 0; k <= x; k++) vr[k] = mem[12'(ir + k)];
          default: return ST_UNKNOWN;
        endcase
        advance(2);
      end
    endcase
    return ST_OK;
  endfunction

  function automatic response_t predict_response(request_t r);
    response_t p;
    p = '{status: ST_OK, opcode_seen: '0, pc_now: '0, beep: 1'b0, fb_row: '0};
    case (func_e'(r.func))
      FN_STEP: begin
        p.opcode_seen = {mem[pc], mem[pc + 12'd1]};
        p.status = run_opcode(p.opcode_seen, r.random_byte, r.key_mask);
      end
      FN_TICK: begin
        if (delay_t > 0) delay_t--;
        if (sound_t > 0) begin
          sound_t--;
          if (sound_t == 1) p.beep = 1'b1;
        end
      end
      FN_LOAD: mem_wr(r.address, r.data);
      default: p.fb_row = screen[r.row_select];
    endcase
    p.pc_now = pc;
    return p;
  endfunction

  // every memory byte the next step will read must be defined
  function automatic bit step_ready(output logic [11:0] miss);
    logic [15:0] op;
    miss = pc;
    if (!written[pc]) return 0;
    miss = pc + 12'd1;
    if (!written[miss]) return 0;
    op = {mem[pc], mem[pc + 12'd1]};
    if (op[15:12] == OpDraw) begin
      for (int r = 0; r < op[3:0]; r++) begin
        miss = 12'(ir + r);
        if (!written[miss]) return 0;
      end
    end
    if (op[15:12] == OpMisc && op[7:0] == NnLoad) begin
      for (int k = 0; k <= op[11:8]; k++) begin
        miss = 12'(ir + k);
        if (!written[miss]) return 0;
      end
    end
    return 1;
  endfunction

  function automatic request_t random_request(func_e f);
    request_t r;
    r.func        = f;
    r.address     = 12'($urandom);
    r.data        = 8'($urandom);
    r.row_select  = 5'($urandom);
    r.random_byte = 8'($urandom);
    r.key_mask    = 16'($urandom);
    return r;
  endfunction

  task automatic queue_request(request_t r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(predict_response(r));
    phase_items++;
  endtask

  task automatic queue_load(logic [11:0] a, logic [7:0] d);
    request_t r;
    r = random_request(FN_LOAD);
    r.address = a;
    r.data = d;
    queue_request(r);
  endtask

  task automatic queue_step();
    logic [11:0] miss;
    while (!step_ready(miss)) queue_load(miss, 8'($urandom));
    queue_request(random_request(FN_STEP));
  endtask

  task automatic queue_opcode(logic [15:0] op);
    queue_load(pc, op[15:8]);
    queue_load(pc + 12'd1, op[7:0]);
    queue_step();
  endtask

  function automatic logic [15:0] random_opcode(int call_pct);
    logic [3:0]  nib;
    logic [3:0]  x;
    logic [7:0]  nn;
    logic [15:0] op;
    int          sel;
    op  = 16'($urandom);
    x   = op[11:8];
    nib = ($urandom_range(99) < call_pct) ? OpCall : 4'($urandom_range(15));
    op[15:12] = nib;
    sel = $urandom_range(9);
    case (nib)
      OpSys: begin
        nn = (sel < 4) ? NnCls : (sel < 8) ? NnRet : op[7:0];
        op = {OpSys, x, nn};
      end
      OpLd: if (sel < 3) op[7:0] = 8'($urandom_range(4));
      OpAlu: begin
        case (sel)
          0: op[3:0] = AluMov;
          1: op[3:0] = AluOr;
          2: op[3:0] = AluAnd;
          3: op[3:0] = AluXor;
          4: op[3:0] = AluAdd;
          5: op[3:0] = AluSub;
          6: op[3:0] = AluShr;
          7: op[3:0] = AluSubn;
          8: op[3:0] = AluShl;
          default: ;
        endcase
      end
      OpKey: begin
        if (sel < 5) op[7:0] = NnSkp;
        else if (sel < 9) op[7:0] = NnSknp;
      end
      OpMisc: begin
        case (sel)
          0: op[7:0] = NnGetDt;
          1: op[7:0] = ($urandom_range(3) == 0) ? NnWaitKey : NnSetDt;
          2: op[7:0] = NnSetDt;
          3: op[7:0] = NnSetSt;
          4: op[7:0] = NnAddI;
          5: op[7:0] = NnFont;
          6: op[7:0] = NnBcd;
          7: op[7:0] = NnStore;
          8: op[7:0] = NnLoad;
          default: ;
        endcase
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    errors++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_boot_pc(logic [11:0] v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    boot_pc = v;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_fired) begin
        void'(pending_reqs.pop_front());
        req_fired = 0;
        req_busy  = 0;
      end
      if (!req_busy && pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
        req_busy = 1;
      if (req_busy) begin
        rq.func        <= pending_reqs[0].func;
        rq.address     <= pending_reqs[0].address;
        rq.data        <= pending_reqs[0].data;
        rq.row_select  <= pending_reqs[0].row_select;
        rq.random_byte <= pending_reqs[0].random_byte;
        rq.key_mask    <= pending_reqs[0].key_mask;
      end
      rq.valid <= req_busy;
      rs.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    response_t want;
    cycle_count++;
    if (rq.valid && rq.ready) req_fired = 1;
    if (rst_ni && rs.valid && rs.ready) begin
      if (expected_rsps.size() == 0) begin
        flag_mismatch("unexpected response", rs.pc_now, '0);
      end else begin
        want = expected_rsps.pop_front();
        if (rs.status !== want.status) flag_mismatch("status", rs.status, want.status);
        if (rs.opcode_seen !== want.opcode_seen)
          flag_mismatch("opcode_seen", rs.opcode_seen, want.opcode_seen);
        if (rs.pc_now !== want.pc_now) flag_mismatch("pc_now", rs.pc_now, want.pc_now);
        if (rs.beep !== want.beep) flag_mismatch("beep", rs.beep, want.beep);
        if (rs.fb_row !== want.fb_row) flag_mismatch("fb_row", rs.fb_row, want.fb_row);
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("chip8_instruction_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    request_t r;
    int       pick;
    int       call_pct;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rq.valid = 1'b0;
    rq.func = '0;
    rq.address = '0;
    rq.data = '0;
    rq.row_select = '0;
    rq.random_byte = '0;
    rq.key_mask = '0;
    rs.ready = 1'b0;
    errors = 0;
    cycle_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    req_fired = 0;
    req_busy = 0;
    boot_pc = PcReset;
    for (int k = 0; k < 16; k++) vr[k] = '0;
    for (int k = 0; k < 32; k++) screen[k] = '0;
    for (int k = 0; k < 4096; k++) written[k] = 1'b0;
    ir = '0;
    pc = PcReset;
    depth = 0;
    delay_t = '0;
    sound_t = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes and corner cases
    write_boot_pc(12'd0);
    phase_items = 0;
    r = random_request(FN_READ);
    r.row_select = 5'd0;
    queue_request(r);
    r.row_select = 5'd31;
    queue_request(r);
    queue_request(random_request(FN_TICK));
    queue_load(12'd0, 8'd0);
    queue_load(12'hFFF, 8'hFF);
    queue_opcode({OpSys, 4'h0, NnRet});       // return on empty stack
    queue_opcode(16'h0123);                   // unknown group-0 code
    queue_opcode({OpMisc, 4'h0, NnWaitKey});
    queue_opcode(16'h6FFF);
    queue_opcode(16'h6E01);
    queue_opcode({OpAlu, 4'hF, 4'hE, AluAdd}); // flag register as destination
    queue_opcode({OpAlu, 4'hF, 4'hE, AluSub});
    queue_opcode({OpAlu, 4'hF, 4'hE, AluSubn});
    queue_opcode({OpAlu, 4'hF, 4'hE, AluShr});
    queue_opcode({OpAlu, 4'hF, 4'hE, AluShl});
    queue_opcode(16'hD010);                   // zero-height sprite
    queue_opcode(16'hAFFE);
    queue_opcode(16'hD01F);                   // sprite read wraps memory
    queue_opcode({OpKey, 4'h0, NnSkp});
    queue_opcode({OpKey, 4'hE, NnSknp});
    queue_opcode(16'h6203);
    queue_opcode({OpMisc, 4'h2, NnSetSt});
    queue_request(random_request(FN_TICK));
    queue_request(random_request(FN_TICK));
    queue_opcode({OpMisc, 4'hF, NnBcd});
    queue_opcode(16'h2ABC);
    queue_opcode({OpSys, 4'h0, NnRet});
    queue_opcode(16'h1FFE);
    queue_opcode(16'h3000);                   // skip wraps the program counter
    queue_opcode({OpSys, 4'h0, NnCls});

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: write_boot_pc(12'hFFF);
        1: write_boot_pc(12'($urandom));
        2: write_boot_pc(PcReset);
        default: write_boot_pc(12'($urandom));
      endcase
      idle_pct  = (phase % 4 == 1) ? 46 : (phase % 4 == 3) ? 36 : 0;
      stall_pct = (phase % 4 == 2) ? 46 : (phase % 4 == 3) ? 36 : 0;
      call_pct  = (phase == 4) ? 40 : 0;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 55) queue_opcode(random_opcode(call_pct));
        else if (pick < 70) queue_step();
        else if (pick < 80) queue_request(random_request(FN_TICK));
        else if (pick < 90) queue_request(random_request(FN_READ));
        else queue_request(random_request(FN_LOAD));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("chip8_instruction_core_tb OK");
    end else begin
      $display("chip8_instruction_core_tb NOT OK");
    end
    $finish;
  end

endmodule
